// ===== hw/rtl/mrf_pkg.sv =====
// shared types, codes and crc helper for the modbus rtu request framer
package mrf_pkg;

    // item kinds on the input channel
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    // configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_MAX_FRAME  = 1'b1;

    // modbus function codes
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS   = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT_RG = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

    localparam logic [15:0] COIL_ON_WORD  = 16'hFF00;
    localparam logic [15:0] COIL_OFF_WORD = 16'h0000;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // rtu frame limit and fixed frame overheads
    localparam logic [17:0] RTU_MAX_FRAME = 18'd256;
    localparam logic [17:0] FIXED_LEN     = 18'd8;
    localparam logic [17:0] MULTI_LEN     = 18'd9;

    localparam logic [2:0] HDR_BYTES   = 3'd6;
    localparam logic [2:0] MULTI_BYTES = 3'd7;
    localparam logic [2:0] LAST_BIT    = 3'd7;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_COILS,
        KIND_REGS
    } frame_kind_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_FUNC,
        STAT_TOO_LONG,
        STAT_ORDER
    } status_t;

    // one command from front to back: up to seven bytes, an optional crc, or an error
    typedef struct packed {
        logic             err;
        status_t          status;
        logic [2:0]       nbytes;
        logic             append_crc;
        logic [6:0][7:0]  bytes;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/mrf_front.sv =====
// front end: accepts items, checks them, tracks the open frame and issues byte commands
module mrf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          opcode,
    input  logic [7:0]    function_code,
    input  logic [15:0]   start_address,
    input  logic [15:0]   quantity,
    input  logic [15:0]   value,
    input  logic [7:0]    slave_address,
    input  logic [8:0]    max_frame_bytes,
    input  logic          q_full,
    output logic          push,
    output mrf_pkg::cmd_t cmd
);
    import mrf_pkg::*;

    frame_kind_t kind_reg, kind_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  pack_reg, pack_next;
    logic [2:0]  bitpos_reg, bitpos_next;

    logic        accept;
    logic [16:0] qty_round;
    logic [13:0] coil_bytes;
    logic [17:0] frame_len;
    logic        too_long;
    logic        known_fc;
    logic        multi;
    logic [15:0] word2;
    logic [15:0] remain_dec;
    logic [7:0]  pack_set;
    logic        emit;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        qty_round  = {1'b0, quantity} + 17'd7;
        coil_bytes = qty_round[16:3];
        multi      = (function_code == FC_WRITE_COILS) || (function_code == FC_WRITE_REGS);
        known_fc   = multi || ((function_code >= FC_READ_COILS) &&
                               (function_code <= FC_WRITE_REG));
        if (function_code == FC_WRITE_COILS)
        begin
            frame_len = MULTI_LEN + {4'b0, coil_bytes};
        end
        else if (function_code == FC_WRITE_REGS)
        begin
            frame_len = MULTI_LEN + {1'b0, quantity, 1'b0};
        end
        else
        begin
            frame_len = FIXED_LEN;
        end
        too_long = (frame_len > {9'b0, max_frame_bytes}) || (frame_len > RTU_MAX_FRAME);

        if (function_code == FC_WRITE_COIL)
        begin
            word2 = (value != 16'h0000) ? COIL_ON_WORD : COIL_OFF_WORD;
        end
        else if (function_code == FC_WRITE_REG)
        begin
            word2 = value;
        end
        else
        begin
            word2 = quantity;
        end

        remain_dec = remain_reg - 16'd1;
        pack_set   = pack_reg | ({7'b0, (value != 16'h0000)} << bitpos_reg);

        kind_next   = kind_reg;
        remain_next = remain_reg;
        pack_next   = pack_reg;
        bitpos_next = bitpos_reg;
        cmd         = '0;
        emit        = 1'b0;

        case (opcode)
            OP_HEADER:
            begin
                emit = 1'b1;
                if (kind_reg != KIND_NONE)
                begin
                    cmd.err    = 1'b1;
                    cmd.status = STAT_ORDER;
                end
                else if (!known_fc)
                begin
                    cmd.err    = 1'b1;
                    cmd.status = STAT_BAD_FUNC;
                end
                else if (too_long)
                begin
                    cmd.err    = 1'b1;
                    cmd.status = STAT_TOO_LONG;
                end
                else
                begin
                    cmd.bytes[0] = slave_address;
                    cmd.bytes[1] = function_code;
                    cmd.bytes[2] = start_address[15:8];
                    cmd.bytes[3] = start_address[7:0];
                    cmd.bytes[4] = word2[15:8];
                    cmd.bytes[5] = word2[7:0];
                    // byte count is frame length less nine, always below 248
                    cmd.bytes[6] = (function_code == FC_WRITE_COILS) ? coil_bytes[7:0]
                                                                   : {quantity[6:0], 1'b0};
                    cmd.nbytes     = multi ? MULTI_BYTES : HDR_BYTES;
                    cmd.append_crc = !multi || (quantity == 16'h0000);
                    if (multi && (quantity != 16'h0000))
                    begin
                        kind_next   = (function_code == FC_WRITE_COILS) ? KIND_COILS : KIND_REGS;
                        remain_next = quantity;
                        pack_next   = 8'h00;
                        bitpos_next = 3'd0;
                    end
                end
            end
            OP_DATA:
            begin
                case (kind_reg)
                    KIND_COILS:
                    begin
                        remain_next = remain_dec;
                        if ((bitpos_reg == LAST_BIT) || (remain_dec == 16'h0000))
                        begin
                            emit         = 1'b1;
                            cmd.bytes[0] = pack_set;
                            cmd.nbytes   = 3'd1;
                            pack_next    = 8'h00;
                            bitpos_next  = 3'd0;
                        end
                        else
                        begin
                            pack_next   = pack_set;
                            bitpos_next = bitpos_reg + 3'd1;
                        end
                        if (remain_dec == 16'h0000)
                        begin
                            cmd.append_crc = 1'b1;
                            kind_next      = KIND_NONE;
                        end
                    end
                    KIND_REGS:
                    begin
                        emit         = 1'b1;
                        cmd.bytes[0] = value[15:8];
                        cmd.bytes[1] = value[7:0];
                        cmd.nbytes   = 3'd2;
                        remain_next  = remain_dec;
                        if (remain_dec == 16'h0000)
                        begin
                            cmd.append_crc = 1'b1;
                            kind_next      = KIND_NONE;
                        end
                    end
                    default:
                    begin
                        emit       = 1'b1;
                        cmd.err    = 1'b1;
                        cmd.status = STAT_ORDER;
                    end
                endcase
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // any error closes the open frame
        if (cmd.err)
        begin
            kind_next   = KIND_NONE;
            remain_next = 16'h0000;
            pack_next   = 8'h00;
            bitpos_next = 3'd0;
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_NONE;
            remain_reg <= 16'h0000;
            pack_reg   <= 8'h00;
            bitpos_reg <= 3'd0;
        end
        else if (accept)
        begin
            kind_reg   <= kind_next;
            remain_reg <= remain_next;
            pack_reg   <= pack_next;
            bitpos_reg <= bitpos_next;
        end
    end

endmodule

// ===== hw/rtl/mrf_cmd_queue.sv =====
// short command queue between front and back
module mrf_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  mrf_pkg::cmd_t                cmd_in,
    input  logic                         pop,
    output mrf_pkg::cmd_t                cmd_out,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);
    import mrf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == LVL_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + LVL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - LVL_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/mrf_back.sv =====
// back end: walks each command byte by byte, runs the crc and drives the output register
module mrf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  mrf_pkg::cmd_t cmd,
    input  logic          q_empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    frame_byte,
    output logic          last_byte,
    output logic [1:0]    status
);
    import mrf_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg;
    logic [7:0]  byte_reg, byte_sel;
    logic        last_reg, last_sel;
    status_t     status_reg, status_sel;
    logic        adv, fire;
    logic [3:0]  nb;

    assign adv  = !out_valid_reg || out_ready;
    assign fire = adv && !q_empty;
    assign nb   = {1'b0, cmd.nbytes};

    always_comb
    begin
        byte_sel   = 8'h00;
        last_sel   = 1'b0;
        status_sel = STAT_OK;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        pop        = 1'b0;
        if (cmd.err)
        begin
            last_sel   = 1'b1;
            status_sel = cmd.status;
            crc_next   = CRC_INIT;
            idx_next   = 4'd0;
            pop        = 1'b1;
        end
        else if (idx_reg < nb)
        begin
            byte_sel = cmd.bytes[idx_reg[2:0]];
            crc_next = crc_byte(crc_reg, byte_sel);
            if ((idx_reg == nb - 4'd1) && !cmd.append_crc)
            begin
                idx_next = 4'd0;
                pop      = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
        else if (idx_reg == nb)
        begin
            // crc goes out low byte first
            byte_sel = crc_reg[7:0];
            idx_next = idx_reg + 4'd1;
        end
        else
        begin
            byte_sel = crc_reg[15:8];
            last_sel = 1'b1;
            crc_next = CRC_INIT;
            idx_next = 4'd0;
            pop      = 1'b1;
        end
        if (!fire)
        begin
            pop      = 1'b0;
            idx_next = idx_reg;
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
            if (adv)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg   <= byte_sel;
            last_reg   <= last_sel;
            status_reg <= status_sel;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;
    assign status     = status_reg;

endmodule

// ===== hw/rtl/modbus_rtu_request_framer.sv =====
// top level of the modbus rtu request framer: config registers, front, queue and back
//
// usage:
//   input channel (in_valid/in_ready): a header item (opcode 0) opens a request;
//   for function codes 15 and 16 it is followed by quantity data items (opcode 1)
//   output channel (out_valid/out_ready): one frame byte per item, crc low byte
//   first, last_byte marks the final crc byte; an error gives a single zero byte
//   with last_byte set and a nonzero status
//   config port: cfg_write with cfg_index 0 sets the slave address, 1 the
//   frame length limit; write only while the block is idle
// timing:
//   with the queue and output empty, the first byte of an item is valid one cycle
//   after the item is accepted and can be taken at the second edge
//   the back end sends one byte per cycle: a read or single write takes 8 cycles,
//   a multi-write header 7 (9 when empty), a register item 2 (4 with the crc),
//   a coil item 0 or 1 (3 with the crc); the output byte rate is set by the back
//   end's single byte lane
//   the front takes one item per cycle while the command queue has room, so short
//   data items keep flowing while a header is still draining
// reset: no frame open, crc at ffff, queue and output empty, slave address 1,
//   frame limit 256
// stall: with out_ready low the output byte holds, the back end waits, and
//   the front keeps accepting until the queue fills, then drops in_ready
module modbus_rtu_request_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  function_code,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic [1:0]  status,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import mrf_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    logic [7:0] slave_addr_reg;
    logic [8:0] max_frame_reg;

    // front to queue to back
    cmd_t             front_cmd, head_cmd;
    logic             push, pop;
    logic             q_full, q_empty;
    logic [LVL_W-1:0] q_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd1;
            max_frame_reg  <= 9'd256;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[7:0];
                CFG_MAX_FRAME:  max_frame_reg  <= cfg_data;
                default:        slave_addr_reg <= slave_addr_reg;
            endcase
        end
    end

    // classify items and keep the open-frame state
    mrf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .function_code   (function_code),
        .start_address   (start_address),
        .quantity        (quantity),
        .value           (value),
        .slave_address   (slave_addr_reg),
        .max_frame_bytes (max_frame_reg),
        .q_full          (q_full),
        .push            (push),
        .cmd             (front_cmd)
    );

    // decouples item intake from byte output
    mrf_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .full    (q_full),
        .empty   (q_empty),
        .level   (q_level)
    );

    // byte sequencer with crc and output register
    mrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .status     (status)
    );

    // an error item is always a single closing zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> last_byte && (frame_byte == 8'h00))
    else $error("error item is not a closing zero byte");

    // queue occupancy never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= LVL_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

    // a command pushed into an empty queue is visible to the back end next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push && q_empty |=> !q_empty)
    else $error("pushed command lost");

    // the front stalls only when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_full)
    else $error("input stalled with room in the queue");

endmodule
